// ===== design/ttbc_pkg.sv =====
`timescale 1ns / 1ps

package ttbc_pkg;

	localparam int OP_W         = 2;
	localparam int TIME_W       = 32;
	localparam int ELAPSED_W    = 16;
	localparam int COUNT_W      = 16;
	localparam int FRAC_W       = 17;
	localparam int SUB_W        = 3;
	localparam int PERIOD_W     = 14;
	localparam int LED_W        = 3;
	localparam int TIMEOUT_W    = 13;
	localparam int GAP_W        = 12;
	localparam int TICKS_SUM_W  = 17;

	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 13;

	localparam int WINDOW_LEN_DEF = 4;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 13'd3000;
	localparam logic                 EASY_RESET    = 1'b1;
	localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 14'd500;
	localparam logic [LED_W-1:0]     LED_FULL      = 3'd5;
	localparam logic [FRAC_W-1:0]    FRAC_ONE      = 17'd65536;
	localparam logic [FRAC_W-1:0]    FRAC_HALF     = 17'd32768;
	localparam logic [17:0]          SMOOTH_THREE  = 18'd196608;

	localparam int DVD_W = 30;
	localparam int CNT_W = 5;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int PH_STEPS  = PERIOD_W + 16;
	localparam int MOD_STEPS = TICKS_SUM_W;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EASY    = 4'd1;

	typedef enum logic [OP_W-1:0] {
		OP_TAP     = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_FRAME   = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TAP_CHK,
		S_SUM,
		S_AVG_DIV,
		S_ADV_CHK,
		S_MOD_DIV,
		S_ADV_END,
		S_PH_LOAD,
		S_PH_DIV,
		S_TRI,
		S_SQR,
		S_CUBE_LOAD,
		S_CUBE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic                beat_flag;
		logic                tap_flag;
		logic [COUNT_W-1:0]  beat_number;
		logic [FRAC_W-1:0]   phase;
		logic [FRAC_W-1:0]   triangle;
		logic [FRAC_W-1:0]   smooth_pulse;
		logic [FRAC_W-1:0]   measure_pos;
		logic [SUB_W-1:0]    sub_beat;
		logic [PERIOD_W-1:0] period_ms;
		logic [LED_W-1:0]    led_level;
	} res_t;

endpackage

// ===== design/ttbc_if.sv =====
`timescale 1ns / 1ps

interface ttbc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ttbc_pkg::CFG_IDX_W-1:0]  index;
	logic [ttbc_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface ttbc_item_if;
	logic                           valid;
	logic                           ready;
	logic [ttbc_pkg::OP_W-1:0]      operation;
	logic [ttbc_pkg::TIME_W-1:0]    tap_time_ms;
	logic [ttbc_pkg::ELAPSED_W-1:0] elapsed_ms;

	modport source(output valid, operation, tap_time_ms, elapsed_ms, input ready);
	modport sink(input valid, operation, tap_time_ms, elapsed_ms, output ready);
endinterface

interface ttbc_result_if;
	logic                          valid;
	logic                          ready;
	logic                          beat_flag;
	logic                          tap_flag;
	logic [ttbc_pkg::COUNT_W-1:0]  beat_number;
	logic [ttbc_pkg::FRAC_W-1:0]   phase;
	logic [ttbc_pkg::FRAC_W-1:0]   triangle;
	logic [ttbc_pkg::FRAC_W-1:0]   smooth_pulse;
	logic [ttbc_pkg::FRAC_W-1:0]   measure_pos;
	logic [ttbc_pkg::SUB_W-1:0]    sub_beat;
	logic [ttbc_pkg::PERIOD_W-1:0] period_ms;
	logic [ttbc_pkg::LED_W-1:0]    led_level;

	modport source(output valid, beat_flag, tap_flag, beat_number, phase, triangle,
		smooth_pulse, measure_pos, sub_beat, period_ms, led_level, input ready);
	modport sink(input valid, beat_flag, tap_flag, beat_number, phase, triangle,
		smooth_pulse, measure_pos, sub_beat, period_ms, led_level, output ready);
endinterface

// ===== design/tap_tempo_beat_clock.sv =====
`timescale 1ns / 1ps

// Tap-tempo beat clock. One request in, one result out; the block works on one
// request at a time and takes the next while the last result waits in the output
// register. A frame tick, an unused operation or a tap past the timeout goes
// straight to the result. A time advance passes through one shared bit-serial
// restoring divider (30 steps for the Q1.16 phase, 17 for the remainder when it
// wraps) and one shift-add multiplier (18 steps each for the square and the cube
// of the smoothstep). An averaged tap first sums the window one entry a cycle and
// then makes one more pass of the divider for the average before the phase steps.
// Register writes are always ready.
module tap_tempo_beat_clock #(
	parameter int WINDOW_LEN = ttbc_pkg::WINDOW_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ttbc_cfg_if.sink      cfg,
	ttbc_item_if.sink     item,
	ttbc_result_if.source result
);

	localparam int FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int PTR_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SUM_W  = ttbc_pkg::GAP_W + $clog2(WINDOW_LEN);
	localparam int DVD_W  = ttbc_pkg::DVD_W;
	localparam int DVS_W  = ttbc_pkg::PERIOD_W;
	localparam int CNT_W  = ttbc_pkg::CNT_W;
	localparam int A_W    = ttbc_pkg::MUL_A_W;
	localparam int B_W    = ttbc_pkg::MUL_B_W;
	localparam int P_W    = ttbc_pkg::MUL_P_W;

	ttbc_pkg::state_t state_q, state_d;

	logic [ttbc_pkg::TIMEOUT_W-1:0] timeout_q;
	logic                           easy_q;
	logic [ttbc_pkg::TIME_W-1:0]    last_tap_q;
	logic [FILL_W-1:0]              fill_q;
	logic [PTR_W-1:0]               ptr_q;
	logic [ttbc_pkg::PERIOD_W-1:0]  period_q;
	logic [ttbc_pkg::PERIOD_W-1:0]  ticks_q;
	logic                           pend_beat_q;
	logic                           pend_tap_q;
	logic                           fired_q;
	logic [ttbc_pkg::COUNT_W-1:0]   counter_q;
	logic [ttbc_pkg::LED_W-1:0]     led_q;
	logic [ttbc_pkg::FRAC_W-1:0]    ph_q;
	logic [ttbc_pkg::FRAC_W-1:0]    tri_q;
	logic [ttbc_pkg::FRAC_W-1:0]    sm_q;
	logic                           res_valid_q;
	ttbc_pkg::res_t                 res_q;

	logic [ttbc_pkg::GAP_W-1:0]       window_q [WINDOW_LEN];
	logic [ttbc_pkg::TIME_W-1:0]      gap_q;
	logic [ttbc_pkg::TICKS_SUM_W-1:0] t_q;
	logic                             wrap_q;
	logic [SUM_W-1:0]                 sum_q;
	logic [PTR_W-1:0]                 idx_q;
	logic [DVS_W-1:0]                 div_rem_q;
	logic [DVD_W-1:0]                 div_dvd_q;
	logic [DVS_W-1:0]                 div_dvs_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [A_W-1:0]                   mul_a_q;
	logic [B_W-1:0]                   mul_b_q;
	logic [P_W-1:0]                   mul_p_q;

	logic                          item_acc;
	logic                          res_free;
	logic                          gap_big;
	logic [ttbc_pkg::GAP_W-1:0]    gap_sat;
	logic                          wrap;
	logic                          last_entry;
	logic [SUM_W-1:0]              sum_next;
	logic                          steps_done;
	logic [DVS_W:0]                div_trial;
	logic                          div_ge;
	logic [DVS_W:0]                div_diff;
	logic [DVS_W-1:0]              div_rem_next;
	logic [ttbc_pkg::GAP_W-1:0]    avg;
	logic [ttbc_pkg::PERIOD_W-1:0] period_raw;
	logic [ttbc_pkg::PERIOD_W-1:0] period_new;
	logic [ttbc_pkg::FRAC_W-1:0]   quot;
	logic [ttbc_pkg::FRAC_W-1:0]   ph_new;
	logic [ttbc_pkg::FRAC_W-1:0]   tri_diff;
	logic [ttbc_pkg::FRAC_W-1:0]   tri_calc;
	logic [B_W-1:0]                cube_mult;
	logic [A_W:0]                  mul_sum;
	logic [ttbc_pkg::FRAC_W+1:0]   meas_sum;

	assign item_acc   = item.valid && item.ready;
	assign res_free   = !res_valid_q || result.ready;
	assign cfg.ready  = 1'b1;

	assign gap_big    = gap_q >= ttbc_pkg::TIME_W'(timeout_q);
	assign gap_sat    = (|gap_q[ttbc_pkg::TIME_W-1:ttbc_pkg::GAP_W]) ?
		{ttbc_pkg::GAP_W{1'b1}} : gap_q[ttbc_pkg::GAP_W-1:0];
	assign wrap       = t_q > ttbc_pkg::TICKS_SUM_W'(period_q);
	assign last_entry = FILL_W'(idx_q) == (fill_q - FILL_W'(1));
	assign sum_next   = sum_q + SUM_W'(window_q[idx_q]);
	assign steps_done = cnt_q == '0;

	assign div_trial    = {div_rem_q, div_dvd_q[DVD_W-1]};
	assign div_ge       = div_trial >= {1'b0, div_dvs_q};
	assign div_diff     = div_trial - {1'b0, div_dvs_q};
	assign div_rem_next = div_ge ? div_diff[DVS_W-1:0] : div_trial[DVS_W-1:0];

	assign avg        = div_dvd_q[ttbc_pkg::GAP_W-1:0];
	assign period_raw = easy_q ? {avg, 2'b00} : {1'b0, avg, 1'b0};
	assign period_new = (period_raw == '0) ? ttbc_pkg::PERIOD_W'(1) : period_raw;

	assign quot   = div_dvd_q[ttbc_pkg::FRAC_W-1:0];
	assign ph_new = (quot > ttbc_pkg::FRAC_ONE) ? ttbc_pkg::FRAC_ONE : quot;

	assign tri_diff  = (ph_q >= ttbc_pkg::FRAC_HALF) ? (ph_q - ttbc_pkg::FRAC_HALF) :
		(ttbc_pkg::FRAC_HALF - ph_q);
	assign tri_calc  = {tri_diff[ttbc_pkg::FRAC_W-2:0], 1'b0};
	assign cube_mult = ttbc_pkg::SMOOTH_THREE - {tri_q, 1'b0};
	assign mul_sum   = {1'b0, mul_p_q[P_W-1:B_W]} + (mul_b_q[0] ? {1'b0, mul_a_q} : '0);

	assign meas_sum = {counter_q[1:0], 16'b0} + (ttbc_pkg::FRAC_W + 2)'(ph_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttbc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		unique case (state_q)
			ttbc_pkg::S_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					unique case (item.operation)
						ttbc_pkg::OP_TAP:     state_d = ttbc_pkg::S_TAP_CHK;
						ttbc_pkg::OP_ADVANCE: state_d = ttbc_pkg::S_ADV_CHK;
						default:              state_d = ttbc_pkg::S_FINISH;
					endcase
				end
			end
			ttbc_pkg::S_TAP_CHK: begin
				state_d = gap_big ? ttbc_pkg::S_FINISH : ttbc_pkg::S_SUM;
			end
			ttbc_pkg::S_SUM: begin
				if (last_entry) state_d = ttbc_pkg::S_AVG_DIV;
			end
			ttbc_pkg::S_AVG_DIV: begin
				if (steps_done) state_d = ttbc_pkg::S_PH_LOAD;
			end
			ttbc_pkg::S_ADV_CHK: begin
				state_d = wrap ? ttbc_pkg::S_MOD_DIV : ttbc_pkg::S_ADV_END;
			end
			ttbc_pkg::S_MOD_DIV: begin
				if (steps_done) state_d = ttbc_pkg::S_ADV_END;
			end
			ttbc_pkg::S_ADV_END:   state_d = ttbc_pkg::S_PH_LOAD;
			ttbc_pkg::S_PH_LOAD:   state_d = ttbc_pkg::S_PH_DIV;
			ttbc_pkg::S_PH_DIV: begin
				if (steps_done) state_d = ttbc_pkg::S_TRI;
			end
			ttbc_pkg::S_TRI:       state_d = ttbc_pkg::S_SQR;
			ttbc_pkg::S_SQR: begin
				if (steps_done) state_d = ttbc_pkg::S_CUBE_LOAD;
			end
			ttbc_pkg::S_CUBE_LOAD: state_d = ttbc_pkg::S_CUBE;
			ttbc_pkg::S_CUBE: begin
				if (steps_done) state_d = ttbc_pkg::S_FINISH;
			end
			ttbc_pkg::S_FINISH: begin
				if (res_free) state_d = ttbc_pkg::S_IDLE;
			end
			default: state_d = ttbc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= ttbc_pkg::TIMEOUT_RESET;
			easy_q      <= ttbc_pkg::EASY_RESET;
			last_tap_q  <= '0;
			fill_q      <= '0;
			ptr_q       <= '0;
			period_q    <= ttbc_pkg::PERIOD_RESET;
			ticks_q     <= '0;
			pend_beat_q <= 1'b0;
			pend_tap_q  <= 1'b0;
			fired_q     <= 1'b0;
			counter_q   <= '0;
			led_q       <= '0;
			ph_q        <= '0;
			tri_q       <= ttbc_pkg::FRAC_ONE;
			sm_q        <= ttbc_pkg::FRAC_ONE;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == ttbc_pkg::REG_TIMEOUT) begin
					timeout_q <= cfg.data[ttbc_pkg::TIMEOUT_W-1:0];
				end else if (cfg.index == ttbc_pkg::REG_EASY) begin
					easy_q <= cfg.data[0];
				end
			end

			if (state_q == ttbc_pkg::S_FINISH && res_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ttbc_pkg::S_IDLE: begin
					if (item_acc) begin
						if (item.operation == ttbc_pkg::OP_TAP) begin
							last_tap_q  <= item.tap_time_ms;
							pend_beat_q <= 1'b1;
							pend_tap_q  <= 1'b1;
						end else if (item.operation == ttbc_pkg::OP_FRAME) begin
							fired_q <= 1'b0;
							if (led_q != '0) led_q <= led_q - ttbc_pkg::LED_W'(1);
						end
					end
				end
				ttbc_pkg::S_TAP_CHK: begin
					if (!gap_big) begin
						ptr_q <= (ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_q + PTR_W'(1);
						if (fill_q != FILL_W'(WINDOW_LEN)) fill_q <= fill_q + FILL_W'(1);
					end
				end
				ttbc_pkg::S_AVG_DIV: begin
					if (steps_done) begin
						period_q <= period_new;
						ticks_q  <= '0;
					end
				end
				ttbc_pkg::S_ADV_CHK: begin
					if (!wrap) ticks_q <= t_q[ttbc_pkg::PERIOD_W-1:0];
				end
				ttbc_pkg::S_MOD_DIV: begin
					if (steps_done) ticks_q <= div_rem_q + ttbc_pkg::PERIOD_W'(1);
				end
				ttbc_pkg::S_ADV_END: begin
					if (wrap_q || pend_beat_q) begin
						counter_q <= counter_q + ttbc_pkg::COUNT_W'(1);
						led_q     <= ttbc_pkg::LED_FULL;
						fired_q   <= 1'b1;
					end else begin
						fired_q <= 1'b0;
					end
					pend_beat_q <= 1'b0;
					pend_tap_q  <= 1'b0;
				end
				ttbc_pkg::S_PH_DIV: begin
					if (steps_done) ph_q <= ph_new;
				end
				ttbc_pkg::S_TRI: begin
					tri_q <= tri_calc;
				end
				ttbc_pkg::S_CUBE: begin
					if (steps_done) sm_q <= mul_p_q[32 +: ttbc_pkg::FRAC_W];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			gap_q <= item.tap_time_ms - last_tap_q;
			t_q   <= ttbc_pkg::TICKS_SUM_W'(ticks_q) + ttbc_pkg::TICKS_SUM_W'(item.elapsed_ms);
		end

		if ((state_q == ttbc_pkg::S_AVG_DIV || state_q == ttbc_pkg::S_MOD_DIV ||
			state_q == ttbc_pkg::S_PH_DIV) && !steps_done) begin
			div_rem_q <= div_rem_next;
			div_dvd_q <= {div_dvd_q[DVD_W-2:0], div_ge};
			cnt_q     <= cnt_q - CNT_W'(1);
		end

		if ((state_q == ttbc_pkg::S_SQR || state_q == ttbc_pkg::S_CUBE) && !steps_done) begin
			mul_p_q <= {mul_sum, mul_p_q[B_W-1:1]};
			mul_b_q <= {1'b0, mul_b_q[B_W-1:1]};
			cnt_q   <= cnt_q - CNT_W'(1);
		end

		unique case (state_q)
			ttbc_pkg::S_TAP_CHK: begin
				if (!gap_big) window_q[ptr_q] <= gap_sat;
				sum_q <= '0;
				idx_q <= '0;
			end
			ttbc_pkg::S_SUM: begin
				sum_q <= sum_next;
				idx_q <= idx_q + PTR_W'(1);
				if (last_entry) begin
					div_rem_q <= '0;
					div_dvd_q <= DVD_W'(sum_next) << (DVD_W - SUM_W);
					div_dvs_q <= DVS_W'(fill_q);
					cnt_q     <= CNT_W'(SUM_W);
				end
			end
			ttbc_pkg::S_ADV_CHK: begin
				wrap_q <= wrap;
				if (wrap) begin
					div_rem_q <= '0;
					div_dvd_q <= {t_q - ttbc_pkg::TICKS_SUM_W'(1),
						(DVD_W - ttbc_pkg::TICKS_SUM_W)'(0)};
					div_dvs_q <= period_q;
					cnt_q     <= CNT_W'(ttbc_pkg::MOD_STEPS);
				end
			end
			ttbc_pkg::S_PH_LOAD: begin
				div_rem_q <= '0;
				div_dvd_q <= {ticks_q, 16'b0};
				div_dvs_q <= period_q;
				cnt_q     <= CNT_W'(ttbc_pkg::PH_STEPS);
			end
			ttbc_pkg::S_TRI: begin
				mul_a_q <= A_W'(tri_calc);
				mul_b_q <= B_W'(tri_calc);
				mul_p_q <= '0;
				cnt_q   <= CNT_W'(B_W);
			end
			ttbc_pkg::S_CUBE_LOAD: begin
				mul_a_q <= mul_p_q[A_W-1:0];
				mul_b_q <= cube_mult;
				mul_p_q <= '0;
				cnt_q   <= CNT_W'(B_W);
			end
			ttbc_pkg::S_FINISH: begin
				if (res_free) begin
					res_q.beat_flag    <= fired_q;
					res_q.tap_flag     <= pend_tap_q;
					res_q.beat_number  <= counter_q;
					res_q.phase        <= ph_q;
					res_q.triangle     <= tri_q;
					res_q.smooth_pulse <= sm_q;
					res_q.measure_pos  <= meas_sum[ttbc_pkg::FRAC_W+1:2];
					res_q.sub_beat     <= ph_q[ttbc_pkg::FRAC_W-1:14];
					res_q.period_ms    <= period_q;
					res_q.led_level    <= led_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid        = res_valid_q;
	assign result.beat_flag    = res_q.beat_flag;
	assign result.tap_flag     = res_q.tap_flag;
	assign result.beat_number  = res_q.beat_number;
	assign result.phase        = res_q.phase;
	assign result.triangle     = res_q.triangle;
	assign result.smooth_pulse = res_q.smooth_pulse;
	assign result.measure_pos  = res_q.measure_pos;
	assign result.sub_beat     = res_q.sub_beat;
	assign result.period_ms    = res_q.period_ms;
	assign result.led_level    = res_q.led_level;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> !item.ready)
		else $error("request taken while another is in flight");

	a_ticks_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttbc_pkg::S_IDLE) |-> (period_q != '0 && ticks_q <= period_q))
		else $error("remainder beyond beat period");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttbc_pkg::S_AVG_DIV || state_q == ttbc_pkg::S_MOD_DIV ||
		state_q == ttbc_pkg::S_PH_DIV) |-> div_rem_q < div_dvs_q)
		else $error("divider remainder not below divisor");

	a_sum_has_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttbc_pkg::S_SUM) |-> (fill_q != '0 && fill_q <= FILL_W'(WINDOW_LEN)))
		else $error("window summed with bad fill count");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttbc_pkg::S_FINISH && res_valid_q && !result.ready) |=>
		(state_q == ttbc_pkg::S_FINISH))
		else $error("result overwritten before it was taken");

endmodule

// ===== dv/ttbc_checker.sv =====
`timescale 1ns / 1ps

module ttbc_checker (
	input  logic   clk,
	input  logic   arst_n,
	ttbc_cfg_if    cfg,
	ttbc_item_if   item,
	ttbc_result_if result,
	output int     fail_count,
	output int     outstanding
);

	bit [ttbc_pkg::TIMEOUT_W-1:0] timeout_ms;
	bit                           easy;
	bit [ttbc_pkg::TIME_W-1:0]    last_tap;
	bit [ttbc_pkg::GAP_W-1:0]     window [ttbc_pkg::WINDOW_LEN_DEF];
	int unsigned                  fill;
	int unsigned                  wptr;
	bit [ttbc_pkg::PERIOD_W-1:0]  period;
	bit [31:0]                    ticks;
	bit                           pend_beat;
	bit                           pend_tap;
	bit                           fired;
	bit [ttbc_pkg::COUNT_W-1:0]   count;
	bit [ttbc_pkg::LED_W-1:0]     led;
	ttbc_pkg::res_t               beat_reports [$];

	task automatic take_tap(input bit [ttbc_pkg::TIME_W-1:0] stamp);
		bit [31:0] gap;
		bit [31:0] sum;
		bit [31:0] avg;
		bit [31:0] per;
		gap = stamp - last_tap;
		last_tap = stamp;
		pend_beat = 1'b1;
		pend_tap = 1'b1;
		if (gap >= 32'(timeout_ms))
			return;
		if (gap > 32'd4095)
			gap = 32'd4095;
		window[wptr] = gap[ttbc_pkg::GAP_W-1:0];
		wptr = (wptr + 1) % ttbc_pkg::WINDOW_LEN_DEF;
		if (fill < ttbc_pkg::WINDOW_LEN_DEF)
			fill++;
		sum = 0;
		for (int i = 0; i < fill; i++)
			sum += 32'(window[i]);
		avg = sum / fill;
		per = easy ? avg * 4 : avg * 2;
		period = (per == 0) ? ttbc_pkg::PERIOD_W'(1) : per[ttbc_pkg::PERIOD_W-1:0];
		ticks = 0;
	endtask

	task automatic take_advance(input bit [ttbc_pkg::ELAPSED_W-1:0] el);
		bit [31:0] t;
		bit        hit;
		t = ticks + 32'(el);
		hit = 1'b0;
		if (t > 32'(period)) begin
			t = ((t - 1) % 32'(period)) + 1;
			hit = 1'b1;
		end
		ticks = t;
		if (hit || pend_beat) begin
			count++;
			led = ttbc_pkg::LED_FULL;
			fired = 1'b1;
		end else begin
			fired = 1'b0;
		end
		pend_beat = 1'b0;
		pend_tap = 1'b0;
	endtask

	function automatic ttbc_pkg::res_t beat_report();
		bit [63:0]      ph;
		bit [63:0]      tl;
		bit [63:0]      sq;
		bit [63:0]      sm;
		bit [63:0]      meas;
		ttbc_pkg::res_t r;
		ph = ({32'd0, ticks} << 16) / 64'(period);
		if (ph > 64'(ttbc_pkg::FRAC_ONE))
			ph = 64'(ttbc_pkg::FRAC_ONE);
		tl = (ph >= 64'(ttbc_pkg::FRAC_HALF)) ? (ph - 64'(ttbc_pkg::FRAC_HALF)) * 2 :
			(64'(ttbc_pkg::FRAC_HALF) - ph) * 2;
		sq = tl * tl;
		sm = (sq * (64'(ttbc_pkg::SMOOTH_THREE) - 2 * tl)) >> 32;
		meas = (({62'd0, count[1:0]} << 16) + ph) >> 2;
		r.beat_flag = fired;
		r.tap_flag = pend_tap;
		r.beat_number = count;
		r.phase = ph[ttbc_pkg::FRAC_W-1:0];
		r.triangle = tl[ttbc_pkg::FRAC_W-1:0];
		r.smooth_pulse = sm[ttbc_pkg::FRAC_W-1:0];
		r.measure_pos = meas[ttbc_pkg::FRAC_W-1:0];
		r.sub_beat = ph[16:14];
		r.period_ms = period;
		r.led_level = led;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ttbc_pkg::res_t want;
		if (!arst_n) begin
			timeout_ms = ttbc_pkg::TIMEOUT_RESET;
			easy = ttbc_pkg::EASY_RESET;
			last_tap = 0;
			foreach (window[i])
				window[i] = 0;
			fill = 0;
			wptr = 0;
			period = ttbc_pkg::PERIOD_RESET;
			ticks = 0;
			pend_beat = 1'b0;
			pend_tap = 1'b0;
			fired = 1'b0;
			count = 0;
			led = 0;
			beat_reports.delete();
			fail_count = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (beat_reports.size() == 0) begin
					$display("%0t: result with no request outstanding", $time);
					fail_count++;
				end else begin
					want = beat_reports[0];
					beat_reports.delete(0);
					check_field("beat_flag", 32'(want.beat_flag), 32'(result.beat_flag));
					check_field("tap_flag", 32'(want.tap_flag), 32'(result.tap_flag));
					check_field("beat_number", 32'(want.beat_number),
						32'(result.beat_number));
					check_field("phase", 32'(want.phase), 32'(result.phase));
					check_field("triangle", 32'(want.triangle), 32'(result.triangle));
					check_field("smooth_pulse", 32'(want.smooth_pulse),
						32'(result.smooth_pulse));
					check_field("measure_pos", 32'(want.measure_pos),
						32'(result.measure_pos));
					check_field("sub_beat", 32'(want.sub_beat), 32'(result.sub_beat));
					check_field("period_ms", 32'(want.period_ms), 32'(result.period_ms));
					check_field("led_level", 32'(want.led_level), 32'(result.led_level));
				end
			end
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					ttbc_pkg::REG_TIMEOUT: timeout_ms = cfg.data[ttbc_pkg::TIMEOUT_W-1:0];
					ttbc_pkg::REG_EASY:    easy = cfg.data[0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				unique case (item.operation)
					ttbc_pkg::OP_TAP:     take_tap(item.tap_time_ms);
					ttbc_pkg::OP_ADVANCE: take_advance(item.elapsed_ms);
					ttbc_pkg::OP_FRAME: begin
						fired = 1'b0;
						if (led > 0)
							led--;
					end
					default: ;
				endcase
				beat_reports = {beat_reports, beat_report()};
			end
		end
		outstanding = beat_reports.size();
	end

endmodule

// ===== dv/tb_tap_tempo_beat_clock.sv =====
`timescale 1ns / 1ps

module tb_tap_tempo_beat_clock;

	localparam logic [ttbc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int N_PHASES       = 8;
	localparam int PHASE_ITEMS    = 180;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   send_idle_pct;
	int   stall_pct;
	int   items_sent;
	int   quiet_cycles;
	bit   hold_req;

	ttbc_cfg_if    cfg_ch ();
	ttbc_item_if   item_ch ();
	ttbc_result_if res_ch ();

	tap_tempo_beat_clock DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (res_ch)
	);

	ttbc_checker tempo_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.item        (item_ch),
		.result      (res_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [ttbc_pkg::OP_W-1:0] op,
		input logic [ttbc_pkg::TIME_W-1:0] stamp,
		input logic [ttbc_pkg::ELAPSED_W-1:0] el);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.tap_time_ms <= stamp;
		item_ch.elapsed_ms <= el;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [ttbc_pkg::CFG_IDX_W-1:0] idx,
		input logic [ttbc_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [ttbc_pkg::TIME_W-1:0]    now_ms;
		logic [ttbc_pkg::TIME_W-1:0]    ts;
		logic [ttbc_pkg::OP_W-1:0]      op;
		logic [ttbc_pkg::TIMEOUT_W-1:0] timeout;
		logic                           easy;
		int unsigned                    iv;
		int unsigned                    n;
		int                             phase_end;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = ttbc_pkg::OP_TAP;
		item_ch.tap_time_ms = '0;
		item_ch.elapsed_ms = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = ttbc_pkg::REG_TIMEOUT;
		cfg_ch.data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		quiet_cycles = 0;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(ttbc_pkg::OP_FRAME, 32'd0, 16'd0);
		send_item(OP_UNUSED, 32'd0, 16'd0);
		send_item(ttbc_pkg::OP_ADVANCE, 32'd0, 16'd0);
		send_item(ttbc_pkg::OP_TAP, 32'd0, 16'd0);
		send_item(ttbc_pkg::OP_ADVANCE, 32'd0, 16'hFFFF);
		send_item(ttbc_pkg::OP_FRAME, 32'd0, 16'd0);
		send_item(ttbc_pkg::OP_TAP, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(ttbc_pkg::OP_TAP, 32'd0, 16'd0);
		send_item(ttbc_pkg::OP_TAP, 32'd600, 16'd0);
		send_item(ttbc_pkg::OP_TAP, 32'd1200, 16'd0);
		send_item(ttbc_pkg::OP_TAP, 32'd1700, 16'd0);
		send_item(ttbc_pkg::OP_ADVANCE, 32'd0, 16'd300);
		send_item(ttbc_pkg::OP_ADVANCE, 32'd0, 16'd1000);
		send_item(ttbc_pkg::OP_FRAME, 32'd0, 16'd0);
		send_item(ttbc_pkg::OP_FRAME, 32'd0, 16'd0);
		send_item(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
		drain();
		write_reg(ttbc_pkg::REG_TIMEOUT, 13'd8191);
		write_reg(ttbc_pkg::REG_EASY, 13'd0);
		send_item(ttbc_pkg::OP_TAP, 32'd10000, 16'd0);
		send_item(ttbc_pkg::OP_TAP, 32'd15000, 16'd0);
		send_item(ttbc_pkg::OP_ADVANCE, 32'd0, 16'hFFFF);
		drain();
		write_reg(ttbc_pkg::REG_TIMEOUT, 13'd0);
		send_item(ttbc_pkg::OP_TAP, 32'd15000, 16'd0);
		send_item(ttbc_pkg::OP_ADVANCE, 32'd0, 16'd7);
		now_ms = 32'd15000;

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			unique case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 73;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 73;
				end
				default: begin
					send_idle_pct = 7;
					stall_pct = 7;
				end
			endcase
			unique case (p)
				0: begin
					timeout = 13'd4096;
					easy = 1'b1;
				end
				1: begin
					timeout = 13'd1;
					easy = 1'b0;
				end
				2: begin
					timeout = 13'd8191;
					easy = 1'b0;
				end
				3: begin
					timeout = 13'd0;
					easy = 1'b1;
				end
				5: begin
					timeout = 13'd3000;
					easy = 1'b1;
				end
				7: begin
					timeout = 13'd2048;
					easy = 1'b0;
				end
				default: begin
					timeout = ttbc_pkg::TIMEOUT_W'($urandom_range(4096, 1));
					easy = 1'($urandom_range(1));
				end
			endcase
			write_reg(ttbc_pkg::REG_TIMEOUT, timeout);
			write_reg(ttbc_pkg::REG_EASY, {12'd0, easy});
			if (p % 4 == 0)
				hold_req = 1'b1;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(9) < 7) begin
					iv = ($urandom_range(9) == 0) ? $urandom_range(6000, 1600) :
						$urandom_range(1600, 0);
					n = $urandom_range(6, 2);
					for (int k = 0; k < n; k++) begin
						now_ms += iv + $urandom_range(40);
						send_item(ttbc_pkg::OP_TAP, now_ms,
							ttbc_pkg::ELAPSED_W'($urandom));
						if ($urandom_range(2) == 0)
							send_item(ttbc_pkg::OP_ADVANCE, $urandom,
								ttbc_pkg::ELAPSED_W'($urandom_range(iv + 20)));
					end
					n = $urandom_range(8, 2);
					for (int k = 0; k < n; k++) begin
						if ($urandom_range(3) == 0)
							send_item(ttbc_pkg::OP_FRAME, $urandom,
								ttbc_pkg::ELAPSED_W'($urandom));
						else
							send_item(ttbc_pkg::OP_ADVANCE, $urandom,
								ttbc_pkg::ELAPSED_W'($urandom_range(3 * iv + 50)));
					end
				end else begin
					op = ttbc_pkg::OP_W'($urandom_range(3));
					ts = $urandom;
					if (op == ttbc_pkg::OP_TAP)
						now_ms = ts;
					send_item(op, ts, ttbc_pkg::ELAPSED_W'($urandom));
				end
			end
		end

		drain();
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
design/ttbc_pkg.sv
design/ttbc_if.sv
design/tap_tempo_beat_clock.sv
dv/ttbc_checker.sv
dv/tb_tap_tempo_beat_clock.sv
